### rtl/nfa_pkg.sv
package nfa_pkg;

	// Address space and tree geometry
	localparam int ADDR_BITS  = 10;
	localparam int NUM_ADDRS  = 1 << ADDR_BITS;
	localparam int NODE_BITS  = ADDR_BITS + 1;
	localparam int COUNT_BITS = ADDR_BITS + 1;
	localparam int NUM_NODES  = 2 * NUM_ADDRS;

	localparam logic [NODE_BITS-1:0]  ROOT_NODE  = NODE_BITS'(1);
	localparam logic [NODE_BITS-1:0]  LAST_NODE  = '1;
	localparam logic [COUNT_BITS-1:0] FULL_COUNT = COUNT_BITS'(NUM_ADDRS);

	// Request action codes
	typedef enum logic [1:0] {
		ACT_ALLOC   = 2'd0,
		ACT_RELEASE = 2'd1,
		ACT_QUERY   = 2'd2
	} action_t;

	// Sequencer states
	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_RD_LEAF,
		ST_LEAF_CHK,
		ST_CLIMB,
		ST_SIB_CHK,
		ST_DESC,
		ST_DESC_CHK,
		ST_SET_LEAF,
		ST_UP_RD,
		ST_UP_CHK,
		ST_CLR_UP,
		ST_DONE
	} state_t;

endpackage

### rtl/nfa_req_if.sv
interface nfa_req_if;
	logic                          valid;
	logic                          ready;
	logic [1:0]                    action;
	logic [nfa_pkg::ADDR_BITS-1:0] address;

	modport source (output valid, action, address, input ready);
	modport sink (input valid, action, address, output ready);
endinterface

### rtl/nfa_rsp_if.sv
interface nfa_rsp_if;
	logic                           valid;
	logic                           ready;
	logic                           status;
	logic [nfa_pkg::ADDR_BITS-1:0]  granted_address;
	logic                           is_free;
	logic [nfa_pkg::COUNT_BITS-1:0] used_count;

	modport source (output valid, status, granted_address, is_free, used_count, input ready);
	modport sink (input valid, status, granted_address, is_free, used_count, output ready);
endinterface

### rtl/nfa_ram.sv
module nfa_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Single port, registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end else begin
			rdata_q <= mem_q[addr];
		end
	end

	assign rdata = rdata_q;

endmodule

### rtl/next_free_address_allocator_top.sv
// Next-free address allocator. Used and full marks live in one single-port RAM
// in heap order (node 1 is the root, leaves at 2^ADDR_BITS + address), walked by
// a small sequencer one RAM access per cycle. After reset a clearing pass writes
// all 2*2^ADDR_BITS RAM words (2048) before the first request is taken. A request
// is taken only while the sequencer is idle. A query reads the leaf. An unused
// action code goes straight to the response. A release of a free address only
// reads the leaf; for a used one it also clears the path to the root. Allocate
// goes straight to the response when the space is full. When the wanted address
// is free, it is marked and each full mark above it is set. Otherwise the walk
// climbs to the next non-full subtree, descends to its lowest free leaf and
// updates the full marks above it, each step one RAM read. A finished response
// sits in an output register, so the next request may start before it is taken.
module next_free_address_allocator_top (
	input  logic      clk,
	input  logic      arst_n,
	nfa_req_if.sink   req,
	nfa_rsp_if.source rsp
);
	import nfa_pkg::*;

	state_t                 state_q, state_d;
	logic [NODE_BITS-1:0]   clr_q;
	logic [NODE_BITS-1:0]   node_q;
	logic [1:0]             action_q;
	logic [COUNT_BITS-1:0]  count_q;
	logic                   status_q;
	logic                   free_q;
	logic [ADDR_BITS-1:0]   grant_q;
	logic                   rsp_valid_q;
	logic                   rsp_status_q;
	logic                   rsp_free_q;
	logic [ADDR_BITS-1:0]   rsp_grant_q;
	logic [COUNT_BITS-1:0]  rsp_count_q;

	logic                   req_ready;
	logic                   ram_we;
	logic [NODE_BITS-1:0]   ram_addr;
	logic                   ram_wdata;
	logic                   ram_rdata;
	logic                   req_fire;
	logic                   rsp_load;

	// Tree storage
	nfa_ram #(
		.WIDTH (1),
		.DEPTH (NUM_NODES)
	) u_tree_ram (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	assign req_fire = req.valid && req_ready;
	assign rsp_load = (state_q == ST_DONE) && (!rsp_valid_q || rsp.ready);

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and RAM control
	always_comb begin
		state_d   = state_q;
		ram_we    = 1'b0;
		ram_addr  = node_q;
		ram_wdata = 1'b0;
		req_ready = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				ram_we   = 1'b1;
				ram_addr = clr_q;
				if (clr_q == LAST_NODE) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				req_ready = 1'b1;
				if (req.valid) begin
					case (req.action)
						ACT_ALLOC:   state_d = (count_q == FULL_COUNT) ? ST_DONE : ST_RD_LEAF;
						ACT_RELEASE: state_d = ST_RD_LEAF;
						ACT_QUERY:   state_d = ST_RD_LEAF;
						default:     state_d = ST_DONE;
					endcase
				end
			end
			ST_RD_LEAF: state_d = ST_LEAF_CHK;
			ST_LEAF_CHK: begin
				case (action_q)
					ACT_ALLOC: state_d = ram_rdata ? ST_CLIMB : ST_SET_LEAF;
					ACT_RELEASE: begin
						if (ram_rdata) begin
							ram_we  = 1'b1;
							state_d = ST_CLR_UP;
						end else begin
							state_d = ST_DONE;
						end
					end
					default: state_d = ST_DONE;
				endcase
			end
			ST_CLIMB: begin
				// root reached: nothing free above, wrap to the lowest free leaf
				if (node_q == ROOT_NODE) begin
					state_d = ST_DESC;
				end else if (!node_q[0]) begin
					ram_addr = node_q | ROOT_NODE;
					state_d  = ST_SIB_CHK;
				end
			end
			ST_SIB_CHK: state_d = ram_rdata ? ST_CLIMB : ST_DESC;
			ST_DESC: begin
				if (node_q[ADDR_BITS]) begin
					state_d = ST_SET_LEAF;
				end else begin
					ram_addr = {node_q[NODE_BITS-2:0], 1'b0};
					state_d  = ST_DESC_CHK;
				end
			end
			ST_DESC_CHK: state_d = ST_DESC;
			ST_SET_LEAF: begin
				ram_we    = 1'b1;
				ram_wdata = 1'b1;
				state_d   = ST_UP_RD;
			end
			ST_UP_RD: begin
				if (node_q == ROOT_NODE) begin
					state_d = ST_DONE;
				end else begin
					ram_addr = node_q ^ ROOT_NODE;
					state_d  = ST_UP_CHK;
				end
			end
			ST_UP_CHK: begin
				// parent is full only when both children are
				if (ram_rdata) begin
					ram_we    = 1'b1;
					ram_wdata = 1'b1;
					ram_addr  = node_q >> 1;
					state_d   = ST_UP_RD;
				end else begin
					state_d = ST_DONE;
				end
			end
			ST_CLR_UP: begin
				ram_we = 1'b1;
				if (node_q == ROOT_NODE) state_d = ST_DONE;
			end
			ST_DONE: begin
				if (!rsp_valid_q || rsp.ready) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign req.ready = req_ready;

	// Control registers: clear pointer, count, response valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q       <= '0;
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_CLEAR) clr_q <= clr_q + NODE_BITS'(1);
			if (state_q == ST_SET_LEAF) count_q <= count_q + COUNT_BITS'(1);
			if (state_q == ST_LEAF_CHK && action_q == ACT_RELEASE && ram_rdata)
				count_q <= count_q - COUNT_BITS'(1);
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Working registers of the current transaction
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (req_fire) begin
					action_q <= req.action;
					node_q   <= {1'b1, req.address};
					grant_q  <= req.address;
					free_q   <= 1'b0;
					status_q <= (req.action == ACT_ALLOC) && (count_q == FULL_COUNT);
				end
			end
			ST_LEAF_CHK: begin
				if (action_q == ACT_QUERY) free_q <= !ram_rdata;
				if (action_q == ACT_RELEASE) node_q <= node_q >> 1;
			end
			ST_CLIMB: begin
				if (node_q != ROOT_NODE) begin
					if (node_q[0]) begin
						node_q <= node_q >> 1;
					end else begin
						node_q <= node_q | ROOT_NODE;
					end
				end
			end
			ST_SIB_CHK: begin
				if (ram_rdata) node_q <= node_q >> 1;
			end
			ST_DESC: begin
				if (!node_q[ADDR_BITS]) node_q <= {node_q[NODE_BITS-2:0], 1'b0};
			end
			ST_DESC_CHK: begin
				if (ram_rdata) node_q <= node_q | ROOT_NODE;
			end
			ST_SET_LEAF: grant_q <= node_q[ADDR_BITS-1:0];
			ST_UP_CHK: begin
				if (ram_rdata) node_q <= node_q >> 1;
			end
			ST_CLR_UP: node_q <= node_q >> 1;
			default: ;
		endcase
	end

	// Response register
	always_ff @(posedge clk) begin
		if (rsp_load) begin
			rsp_status_q <= status_q;
			rsp_grant_q  <= grant_q;
			rsp_free_q   <= free_q;
			rsp_count_q  <= count_q;
		end
	end

	assign rsp.valid           = rsp_valid_q;
	assign rsp.status          = rsp_status_q;
	assign rsp.granted_address = rsp_grant_q;
	assign rsp.is_free         = rsp_free_q;
	assign rsp.used_count      = rsp_count_q;

`ifndef ASSERT_OFF
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FULL_COUNT)
		else $error("used count above address space");

	a_set_is_leaf: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SET_LEAF) |-> node_q[ADDR_BITS])
		else $error("allocation marks a non-leaf node");

	a_walk_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLIMB || state_q == ST_DESC || state_q == ST_UP_RD ||
		 state_q == ST_CLR_UP) |-> (node_q != '0))
		else $error("tree walk left the tree");

	a_alloc_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SET_LEAF) |=> (count_q == $past(count_q) + COUNT_BITS'(1)))
		else $error("allocation did not bump the count");

	a_release_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_LEAF_CHK && action_q == ACT_RELEASE && ram_rdata)
		|=> (count_q == $past(count_q) - COUNT_BITS'(1)))
		else $error("release did not drop the count");
`endif

endmodule
